### hw/rtl/tmrt_pkg.sv
// Shared constants for the two-metric round-trip minimum cost block.
// Field widths, store widths, saturation limits and command codes.
// No dependencies.
package tmrt_pkg;

    localparam int CITY_BITS   = 6;
    localparam int MAX_CITIES  = 64;
    localparam int ADDR_BITS   = 2 * CITY_BITS;
    localparam int NCFG_BITS   = 7;
    localparam int COST_BITS   = 16;
    localparam int PRICE_BITS  = 20;
    localparam int PLAIN_BITS  = 23;
    localparam int LOADED_BITS = 40;
    localparam int OUT_BITS    = 31;
    localparam int SUM_BITS    = 42;

    localparam logic [PLAIN_BITS-1:0]  PLAIN_INF  = '1;
    localparam logic [LOADED_BITS-1:0] LOADED_INF = '1;
    localparam logic [OUT_BITS-1:0]    COST_TOP   = '1;

    localparam logic [1:0] CMD_PRICE = 2'd0;
    localparam logic [1:0] CMD_ROAD  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

endpackage

### hw/rtl/tmrt_if.sv
// Handshake interfaces for the input items and the result items.
// Depends on tmrt_pkg for field widths.
interface tmrt_in_if;
    import tmrt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [1:0]            cmd;
    logic [CITY_BITS-1:0]  node_a;
    logic [CITY_BITS-1:0]  node_b;
    logic [COST_BITS-1:0]  edge_cost;
    logic [COST_BITS-1:0]  carry_factor;
    logic [PRICE_BITS-1:0] price;
    modport source (output valid, cmd, node_a, node_b, edge_cost, carry_factor, price,
                    input ready);
    modport sink (input valid, cmd, node_a, node_b, edge_cost, carry_factor, price,
                  output ready);
endinterface

interface tmrt_out_if;
    import tmrt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CITY_BITS-1:0] city;
    logic [OUT_BITS-1:0]  min_cost;
    logic                 last;
    modport source (output valid, city, min_cost, last, input ready);
    modport sink (input valid, city, min_cost, last, output ready);
endinterface

### hw/rtl/two_metric_round_trip_min_cost.sv
// Top level of the two-metric round-trip minimum cost block.
// Depends on tmrt_pkg and the interfaces in tmrt_if.sv.
//
//   channel   | direction | carries
//   ----------+-----------+-------------------------------------------
//   items     | in        | cmd, node_a, node_b, edge_cost, carry_factor, price
//   results   | out       | city, min_cost, last
//   cfg       | in        | num_cities write, no read-back
//
// A price load is written in the idle state; a road load between two distinct cities
// steps through read, write and mirrored write. A start item runs the relaxation,
// then the result search plus the result stalls, and afterward clears the distance stores.
// The same clearing pass runs after reset; no item is taken meanwhile.
// Both distance stores share one read-modify-write loop on two read ports.
module two_metric_round_trip_min_cost (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tmrt_pkg::NCFG_BITS-1:0] cfg_wdata,
    tmrt_in_if.sink                        items,
    tmrt_out_if.source                     results
);
    import tmrt_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ROAD_CMP, S_ROAD_MIR, S_REL_LEFT, S_REL_COL,
        S_REL_DRAIN, S_FIN_RUN, S_FIN_D1, S_FIN_D2, S_SEND
    } state_t;

    state_t                 state_reg;
    logic [NCFG_BITS-1:0]   ncfg_reg;
    logic [CITY_BITS-1:0]   nlast_reg;
    logic [ADDR_BITS-1:0]   clr_reg;
    logic [CITY_BITS-1:0]   via_reg, row_reg, col_reg, colw_reg;
    logic                   pv_reg;
    logic [PLAIN_BITS-1:0]  left_p_reg;
    logic [LOADED_BITS-1:0] left_l_reg;
    logic [CITY_BITS-1:0]   ra_reg, rb_reg;
    logic [PLAIN_BITS-1:0]  pw_reg;
    logic [LOADED_BITS-1:0] lw_reg;
    logic [CITY_BITS-1:0]   k_reg, j_reg;
    logic                   f1_reg, s1_valid_reg;
    logic [SUM_BITS-1:0]    s1_sum_reg;
    logic [OUT_BITS-1:0]    best_reg;
    logic [MAX_CITIES-1:0]  pvalid_reg;

    logic [PLAIN_BITS-1:0]  plain_mem  [MAX_CITIES*MAX_CITIES];
    logic [LOADED_BITS-1:0] loaded_mem [MAX_CITIES*MAX_CITIES];
    logic [PRICE_BITS-1:0]  price_mem  [MAX_CITIES];

    logic [PLAIN_BITS-1:0]  pa_q, pb_q;
    logic [LOADED_BITS-1:0] la_q, lb_q;
    logic [PRICE_BITS-1:0]  price_q;
    logic                   pvld_q;

    logic [ADDR_BITS-1:0]   pa_addr, la_addr, b_addr, wr_addr;
    logic                   wr_en;
    logic [PLAIN_BITS-1:0]  wr_p, rel_p;
    logic [LOADED_BITS-1:0] wr_l, rel_l;
    logic [PLAIN_BITS:0]    sum_p;
    logic [LOADED_BITS:0]   sum_l;
    logic                   in_fire;
    logic [CITY_BITS-1:0]   nlast_cfg;
    logic [SUM_BITS-1:0]    s1_in;

    assign in_fire = items.valid && items.ready;
    assign items.ready = (state_reg == S_IDLE);
    assign results.valid = (state_reg == S_SEND);
    assign results.city = k_reg;
    assign results.min_cost = best_reg;
    assign results.last = (k_reg == nlast_reg);

    always_comb
    begin
        if (ncfg_reg == '0)
        begin
            nlast_cfg = '0;
        end
        else if (ncfg_reg > NCFG_BITS'(MAX_CITIES))
        begin
            nlast_cfg = CITY_BITS'(MAX_CITIES - 1);
        end
        else
        begin
            nlast_cfg = CITY_BITS'(ncfg_reg - 1'b1);
        end
    end

    always_comb
    begin
        sum_p = {1'b0, left_p_reg} + {1'b0, pb_q};
        sum_l = {1'b0, left_l_reg} + {1'b0, lb_q};
        rel_p = (sum_p >= {1'b0, PLAIN_INF}) ? PLAIN_INF : sum_p[PLAIN_BITS-1:0];
        rel_l = (sum_l >= {1'b0, LOADED_INF}) ? LOADED_INF : sum_l[LOADED_BITS-1:0];
        if (rel_p >= pa_q)
        begin
            rel_p = pa_q;
        end
        if (rel_l >= la_q)
        begin
            rel_l = la_q;
        end
    end

    always_comb
    begin
        pa_addr = {items.node_a, items.node_b};
        la_addr = {items.node_a, items.node_b};
        b_addr  = {via_reg, col_reg};
        wr_en   = 1'b0;
        wr_addr = {row_reg, colw_reg};
        wr_p    = rel_p;
        wr_l    = rel_l;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_p    = (clr_reg[ADDR_BITS-1:CITY_BITS] == clr_reg[CITY_BITS-1:0]) ?
                          '0 : PLAIN_INF;
                wr_l    = (clr_reg[ADDR_BITS-1:CITY_BITS] == clr_reg[CITY_BITS-1:0]) ?
                          '0 : LOADED_INF;
            end
            S_ROAD_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = {ra_reg, rb_reg};
                wr_p    = (pw_reg < pa_q) ? pw_reg : pa_q;
                wr_l    = (lw_reg < la_q) ? lw_reg : la_q;
            end
            S_ROAD_MIR:
            begin
                wr_en   = 1'b1;
                wr_addr = {rb_reg, ra_reg};
                wr_p    = left_p_reg;
                wr_l    = left_l_reg;
            end
            S_REL_LEFT:
            begin
                pa_addr = {row_reg, via_reg};
                la_addr = {row_reg, via_reg};
            end
            S_REL_COL:
            begin
                pa_addr = {row_reg, col_reg};
                la_addr = {row_reg, col_reg};
                wr_en   = pv_reg;
            end
            S_REL_DRAIN:
            begin
                wr_en = 1'b1;
            end
            S_FIN_RUN:
            begin
                pa_addr = {k_reg, j_reg};
                la_addr = {j_reg, k_reg};
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            plain_mem[wr_addr]  <= wr_p;
            loaded_mem[wr_addr] <= wr_l;
        end
        pa_q <= plain_mem[pa_addr];
        pb_q <= plain_mem[b_addr];
        la_q <= loaded_mem[la_addr];
        lb_q <= loaded_mem[b_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && items.cmd == CMD_PRICE)
        begin
            price_mem[items.node_a] <= items.price;
        end
        price_q <= price_mem[j_reg];
    end

    assign s1_in = SUM_BITS'(pvld_q ? price_q : '0) + SUM_BITS'(pa_q) + SUM_BITS'(la_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            ncfg_reg     <= NCFG_BITS'(1);
            nlast_reg    <= '0;
            clr_reg      <= '0;
            via_reg      <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            colw_reg     <= '0;
            pv_reg       <= 1'b0;
            left_p_reg   <= '0;
            left_l_reg   <= '0;
            ra_reg       <= '0;
            rb_reg       <= '0;
            pw_reg       <= '0;
            lw_reg       <= '0;
            k_reg        <= '0;
            j_reg        <= '0;
            f1_reg       <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_sum_reg   <= '0;
            best_reg     <= COST_TOP;
            pvalid_reg   <= '0;
            pvld_q       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ncfg_reg <= cfg_wdata;
            end
            pvld_q       <= pvalid_reg[j_reg];
            f1_reg       <= (state_reg == S_FIN_RUN);
            s1_valid_reg <= f1_reg && (pa_q < PLAIN_INF) && (la_q < LOADED_INF);
            s1_sum_reg   <= s1_in;
            if (s1_valid_reg)
            begin
                if (s1_sum_reg < SUM_BITS'(best_reg))
                begin
                    best_reg <= s1_sum_reg[OUT_BITS-1:0];
                end
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        unique case (items.cmd)
                            CMD_PRICE:
                            begin
                                pvalid_reg[items.node_a] <= 1'b1;
                            end
                            CMD_ROAD:
                            begin
                                ra_reg <= items.node_a;
                                rb_reg <= items.node_b;
                                pw_reg <= PLAIN_BITS'(items.edge_cost);
                                lw_reg <= LOADED_BITS'(32'(items.edge_cost) *
                                                       32'(items.carry_factor));
                                if (items.node_a != items.node_b)
                                begin
                                    state_reg <= S_ROAD_CMP;
                                end
                            end
                            CMD_START:
                            begin
                                nlast_reg <= nlast_cfg;
                                via_reg   <= '0;
                                row_reg   <= '0;
                                col_reg   <= '0;
                                pv_reg    <= 1'b0;
                                state_reg <= S_REL_LEFT;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_ROAD_CMP:
                begin
                    left_p_reg <= wr_p;
                    left_l_reg <= wr_l;
                    state_reg  <= S_ROAD_MIR;
                end
                S_ROAD_MIR:
                begin
                    state_reg <= S_IDLE;
                end
                S_REL_LEFT:
                begin
                    state_reg <= S_REL_COL;
                end
                S_REL_COL:
                begin
                    if (!pv_reg)
                    begin
                        left_p_reg <= pa_q;
                        left_l_reg <= la_q;
                    end
                    pv_reg   <= 1'b1;
                    colw_reg <= col_reg;
                    if (col_reg == nlast_reg)
                    begin
                        state_reg <= S_REL_DRAIN;
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                S_REL_DRAIN:
                begin
                    pv_reg  <= 1'b0;
                    col_reg <= '0;
                    if (row_reg == nlast_reg)
                    begin
                        row_reg <= '0;
                        if (via_reg == nlast_reg)
                        begin
                            k_reg     <= '0;
                            j_reg     <= '0;
                            best_reg  <= COST_TOP;
                            state_reg <= S_FIN_RUN;
                        end
                        else
                        begin
                            via_reg   <= via_reg + 1'b1;
                            state_reg <= S_REL_LEFT;
                        end
                    end
                    else
                    begin
                        row_reg   <= row_reg + 1'b1;
                        state_reg <= S_REL_LEFT;
                    end
                end
                S_FIN_RUN:
                begin
                    if (j_reg == nlast_reg)
                    begin
                        state_reg <= S_FIN_D1;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_FIN_D1:
                begin
                    state_reg <= S_FIN_D2;
                end
                S_FIN_D2:
                begin
                    state_reg <= S_SEND;
                end
                S_SEND:
                begin
                    if (results.ready)
                    begin
                        if (k_reg == nlast_reg)
                        begin
                            clr_reg   <= '0;
                            state_reg <= S_CLEAR;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            j_reg     <= '0;
                            best_reg  <= COST_TOP;
                            state_reg <= S_FIN_RUN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_CLEAR;
                end
            endcase
        end
    end

endmodule

### hw/rtl/tmrt_check.sv
// Port-level checks for the two-metric round-trip minimum cost block.
// Depends on tmrt_pkg; bound to the top level at the end of this file.
module tmrt_check (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           out_last,
    input logic [tmrt_pkg::CITY_BITS-1:0] out_city
);
    import tmrt_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_city) && $stable(out_last))
        else $error("A stalled result item changed.");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("Input taken while a result item is pending.");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !out_valid && !in_ready)
        else $error("Results or input continued right after the last result item.");

    a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> !in_ready)
        else $error("Input taken between result items.");

endmodule

bind two_metric_round_trip_min_cost tmrt_check u_tmrt_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_last  (results.last),
    .out_city  (results.city)
);
